// File: hw/rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define CCO_CHECK(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("cco check failed");

// Checked on every edge, reset included.
`define CCO_CHECK_ALL(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("cco check failed");

`endif

// File: hw/rtl/cco_pkg.sv
// Shared types, constants and Q16.16 helpers for the chase camera core.
`timescale 1ns / 1ps
package cco_pkg;

   localparam int DELAY_DEPTH = 16;
   localparam int RING_AW     = $clog2(DELAY_DEPTH);
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_AW      = 4;

   localparam logic [1:0] MODE_FIXED   = 2'd0;
   localparam logic [1:0] MODE_GLUED   = 2'd1;
   localparam logic [1:0] MODE_DELAYED = 2'd2;

   localparam logic [1:0] REG_MODE      = 2'd0;
   localparam logic [1:0] REG_OFF_RIGHT = 2'd1;
   localparam logic [1:0] REG_OFF_UP    = 2'd2;
   localparam logic [1:0] REG_OFF_FWD   = 2'd3;

   localparam logic [31:0] OFF_RIGHT_RESET = 32'h0000_0000;
   localparam logic [31:0] OFF_UP_RESET    = 32'h0002_0000;
   localparam logic [31:0] OFF_FWD_RESET   = 32'h000F_0000;

   typedef logic [31:0] q16_type;

   typedef struct packed {
      q16_type [2:0] fwd;
      q16_type [2:0] up;
   } cco_orient_type;

   typedef struct packed {
      q16_type [2:0]  pos;
      cco_orient_type ori;
      logic           offset_en;
   } cco_entry_type;

   typedef struct packed {
      q16_type right;
      q16_type up;
      q16_type fwd;
   } cco_offset_type;

   // Q16.16 product, round to nearest, ties up, unsaturated
   function automatic logic signed [47:0] qmul(input logic signed [31:0] a,
                                              input logic signed [31:0] b);
      logic signed [63:0] p;
      p = a * b;
      p = p + 64'sd32768;
      return p[63:16];
   endfunction

   function automatic logic [31:0] sat49(input logic signed [48:0] v);
      if (v > 49'sd2147483647)
         return 32'h7FFF_FFFF;
      else if (v < -49'sd2147483648)
         return 32'h8000_0000;
      else
         return v[31:0];
   endfunction

   function automatic logic [31:0] sat34(input logic signed [33:0] v);
      if (v > 34'sd2147483647)
         return 32'h7FFF_FFFF;
      else if (v < -34'sd2147483648)
         return 32'h8000_0000;
      else
         return v[31:0];
   endfunction

endpackage

// File: hw/rtl/cco_front.sv
// Front end: accepts body words, keeps held orientation and the delay ring.
`timescale 1ns / 1ps
module cco_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  cco_pkg::q16_type [2:0]        body_pos,
   input  cco_pkg::q16_type [2:0]        body_fwd,
   input  cco_pkg::q16_type [2:0]        body_up,
   input  logic [1:0]                    camera_mode,
   input  logic                          q_full,
   output logic                          q_push,
   output cco_pkg::cco_entry_type        q_entry
);
   import cco_pkg::*;

   cco_orient_type        held_ff, held_in;
   cco_orient_type        ring_rd_ff;
   cco_orient_type        ring_mem [DELAY_DEPTH];
   logic [RING_AW-1:0]    head_ff, head_in;
   logic [RING_AW-1:0]    fill_ff, fill_in;
   logic [RING_AW-1:0]    wr_addr;
   logic [RING_AW:0]      wr_sum;
   logic                  pop_ff, pop_in;
   q16_type [2:0]         pend_pos_ff, pend_pos_in;
   logic                  accept, ring_wr, ring_rd, ring_full;
   cco_orient_type        body_ori;

   assign body_ori  = {body_fwd, body_up};
   assign req_ready = !pop_ff && !q_full;
   assign accept    = req_valid && req_ready;
   assign ring_full = (fill_ff == RING_AW'(DELAY_DEPTH - 1));
   assign ring_wr   = accept && (camera_mode == MODE_DELAYED);
   assign ring_rd   = ring_wr && ring_full;
   assign wr_sum    = {1'b0, head_ff} + {1'b0, fill_ff};
   assign wr_addr   = (wr_sum >= (RING_AW + 1)'(DELAY_DEPTH)) ?
                      RING_AW'(wr_sum - (RING_AW + 1)'(DELAY_DEPTH)) :
                      wr_sum[RING_AW-1:0];

   always_comb begin
      held_in     = held_ff;
      head_in     = head_ff;
      fill_in     = fill_ff;
      pop_in      = 1'b0;
      pend_pos_in = pend_pos_ff;
      q_push      = 1'b0;
      q_entry     = {body_pos, held_ff, 1'b0};
      if (pop_ff) begin
         // oldest ring entry becomes the held orientation
         held_in = ring_rd_ff;
         q_push  = 1'b1;
         q_entry = {pend_pos_ff, ring_rd_ff, 1'b1};
      end else if (accept) begin
         case (camera_mode)
            MODE_GLUED: begin
               held_in = body_ori;
               q_push  = 1'b1;
               q_entry = {body_pos, body_ori, 1'b1};
            end
            MODE_DELAYED: begin
               if (ring_full) begin
                  head_in     = (head_ff == RING_AW'(DELAY_DEPTH - 1)) ? '0 :
                                head_ff + 1'b1;
                  pop_in      = 1'b1;
                  pend_pos_in = body_pos;
               end else begin
                  fill_in = fill_ff + 1'b1;
                  q_push  = 1'b1;
                  q_entry = {body_pos, held_ff, 1'b1};
               end
            end
            default: begin
               q_push  = 1'b1;
               q_entry = {body_pos, held_ff, 1'b0};
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
         head_ff <= '0;
         fill_ff <= '0;
         pop_ff  <= 1'b0;
      end else begin
         held_ff <= held_in;
         head_ff <= head_in;
         fill_ff <= fill_in;
         pop_ff  <= pop_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_pos_ff <= pend_pos_in;
   end

   always_ff @(posedge clock) begin
      if (ring_wr) begin
         ring_mem[wr_addr] <= body_ori;
      end
      if (ring_rd) begin
         ring_rd_ff <= ring_mem[head_ff];
      end
   end

endmodule

// File: hw/rtl/cco_fifo.sv
// Short queue between front and back end.
`timescale 1ns / 1ps
module cco_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  cco_pkg::cco_entry_type wr_entry,
   input  logic                   pop,
   output logic                   full,
   output logic                   empty,
   output cco_pkg::cco_entry_type rd_entry
);
   import cco_pkg::*;

   cco_entry_type         slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   count_ff, count_in;

   assign full     = (count_ff == QUEUE_CW'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign rd_entry = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

// File: hw/rtl/cco_back.sv
// Back end: four-step offset sum sequencer and result register.
`timescale 1ns / 1ps
module cco_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_empty,
   input  cco_pkg::cco_entry_type  q_entry,
   output logic                    q_pop,
   input  cco_pkg::cco_offset_type offsets,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output cco_pkg::q16_type [2:0]  cam_pos,
   output cco_pkg::q16_type [2:0]  cam_fwd,
   output cco_pkg::q16_type [2:0]  cam_up
);
   import cco_pkg::*;

   localparam logic [1:0] STEP_CROSS = 2'd0;
   localparam logic [1:0] STEP_PART  = 2'd1;
   localparam logic [1:0] STEP_RIGHT = 2'd2;
   localparam logic [1:0] STEP_SUM   = 2'd3;

   logic                busy_ff, busy_in;
   logic [1:0]          step_ff, step_in;
   logic                rsp_valid_ff, rsp_valid_in;
   cco_entry_type       work_ff, work_in;
   logic signed [47:0]  prod_ff [6];
   logic signed [47:0]  prod_in [6];
   logic signed [31:0]  cross_ff [3];
   logic signed [31:0]  cross_in [3];
   logic signed [31:0]  tf_ff [3];
   logic signed [31:0]  tf_in [3];
   logic signed [31:0]  tu_ff [3];
   logic signed [31:0]  tu_in [3];
   logic signed [31:0]  tr_ff [3];
   logic signed [31:0]  tr_in [3];
   q16_type [2:0]       pos_ff, pos_in;
   cco_orient_type      ori_ff, ori_in;
   q16_type [2:0]       fix_off;
   logic signed [33:0]  sum_v [3];
   logic                out_free, finish, load;

   assign fix_off = {offsets.fwd, offsets.up, offsets.right};
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign finish   = busy_ff && (step_ff == STEP_SUM) && out_free;
   assign load     = !q_empty && (!busy_ff || finish);
   assign q_pop    = load;

   assign rsp_valid = rsp_valid_ff;
   assign cam_pos   = pos_ff;
   assign cam_fwd   = ori_ff.fwd;
   assign cam_up    = ori_ff.up;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (work_ff.offset_en) begin
            sum_v[i] = 34'($signed(work_ff.pos[i])) + 34'(tf_ff[i]) +
                       34'(tu_ff[i]) + 34'(tr_ff[i]);
         end else begin
            sum_v[i] = 34'($signed(work_ff.pos[i])) + 34'($signed(fix_off[i]));
         end
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      work_in      = work_ff;
      prod_in      = prod_ff;
      cross_in     = cross_ff;
      tf_in        = tf_ff;
      tu_in        = tu_ff;
      tr_in        = tr_ff;
      pos_in       = pos_ff;
      ori_in       = ori_ff;
      if (busy_ff) begin
         case (step_ff)
            STEP_CROSS: begin
               // up x fwd, two rounded products per component
               prod_in[0] = qmul(work_ff.ori.up[1], work_ff.ori.fwd[2]);
               prod_in[1] = qmul(work_ff.ori.up[2], work_ff.ori.fwd[1]);
               prod_in[2] = qmul(work_ff.ori.up[2], work_ff.ori.fwd[0]);
               prod_in[3] = qmul(work_ff.ori.up[0], work_ff.ori.fwd[2]);
               prod_in[4] = qmul(work_ff.ori.up[0], work_ff.ori.fwd[1]);
               prod_in[5] = qmul(work_ff.ori.up[1], work_ff.ori.fwd[0]);
               step_in    = STEP_PART;
            end
            STEP_PART: begin
               for (int i = 0; i < 3; i++) begin
                  cross_in[i] = sat49(49'(prod_ff[2*i]) - 49'(prod_ff[2*i+1]));
                  tf_in[i]    = sat49(49'(qmul(work_ff.ori.fwd[i], offsets.fwd)));
                  tu_in[i]    = sat49(49'(qmul(work_ff.ori.up[i], offsets.up)));
               end
               step_in = STEP_RIGHT;
            end
            STEP_RIGHT: begin
               for (int i = 0; i < 3; i++) begin
                  tr_in[i] = sat49(49'(qmul(cross_ff[i], offsets.right)));
               end
               step_in = STEP_SUM;
            end
            STEP_SUM: begin
               if (finish) begin
                  for (int i = 0; i < 3; i++) begin
                     pos_in[i] = sat34(sum_v[i]);
                  end
                  ori_in       = work_ff.ori;
                  rsp_valid_in = 1'b1;
                  busy_in      = 1'b0;
               end
            end
            default: begin
               step_in = STEP_CROSS;
            end
         endcase
      end
      if (load) begin
         busy_in = 1'b1;
         step_in = STEP_CROSS;
         work_in = q_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         step_ff      <= STEP_CROSS;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff  <= work_in;
      prod_ff  <= prod_in;
      cross_ff <= cross_in;
      tf_ff    <= tf_in;
      tu_ff    <= tu_in;
      tr_ff    <= tr_in;
      pos_ff   <= pos_in;
      ori_ff   <= ori_in;
   end

endmodule

// File: hw/rtl/chase_camera_offset_transform_core.sv
// An accepted req word passes the queue into the back end, whose four steps end in rsp_valid.
// The back end takes a new word only as its four-step multiply sequence finishes the last one.
// The front end takes a word per cycle until the 2-entry queue is full; a pending ring pop holds it.
// Synchronous reset restores register defaults, zeroes held orientation and ring pointers.
// Ring contents are not cleared; no clearing pass, the core is ready right after reset.
`timescale 1ns / 1ps
module chase_camera_offset_transform_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic signed [31:0]        req_body_pos_x,
   input  logic signed [31:0]        req_body_pos_y,
   input  logic signed [31:0]        req_body_pos_z,
   input  logic signed [31:0]        req_body_fwd_x,
   input  logic signed [31:0]        req_body_fwd_y,
   input  logic signed [31:0]        req_body_fwd_z,
   input  logic signed [31:0]        req_body_up_x,
   input  logic signed [31:0]        req_body_up_y,
   input  logic signed [31:0]        req_body_up_z,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [31:0]        rsp_cam_pos_x,
   output logic signed [31:0]        rsp_cam_pos_y,
   output logic signed [31:0]        rsp_cam_pos_z,
   output logic signed [31:0]        rsp_cam_fwd_x,
   output logic signed [31:0]        rsp_cam_fwd_y,
   output logic signed [31:0]        rsp_cam_fwd_z,
   output logic signed [31:0]        rsp_cam_up_x,
   output logic signed [31:0]        rsp_cam_up_y,
   output logic signed [31:0]        rsp_cam_up_z,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [cco_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);
   import cco_pkg::*;

   logic [1:0]      mode_ff, mode_in;
   cco_offset_type  off_ff, off_in;
   logic            csr_wr;
   logic [1:0]      csr_idx;

   q16_type [2:0]   body_pos, body_fwd, body_up;
   q16_type [2:0]   cam_pos, cam_fwd, cam_up;
   logic            q_push, q_pop, q_full, q_empty;
   cco_entry_type   q_wr_entry, q_rd_entry;

   // register file
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      mode_in = mode_ff;
      off_in  = off_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_MODE:      mode_in      = csr_pwdata[1:0];
            REG_OFF_RIGHT: off_in.right = csr_pwdata;
            REG_OFF_UP:    off_in.up    = csr_pwdata;
            REG_OFF_FWD:   off_in.fwd   = csr_pwdata;
            default:       mode_in      = mode_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_MODE:      csr_prdata = {30'd0, mode_ff};
         REG_OFF_RIGHT: csr_prdata = off_ff.right;
         REG_OFF_UP:    csr_prdata = off_ff.up;
         REG_OFF_FWD:   csr_prdata = off_ff.fwd;
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_FIXED;
         off_ff.right <= OFF_RIGHT_RESET;
         off_ff.up    <= OFF_UP_RESET;
         off_ff.fwd   <= OFF_FWD_RESET;
      end else begin
         mode_ff <= mode_in;
         off_ff  <= off_in;
      end
   end

   assign body_pos = {req_body_pos_z, req_body_pos_y, req_body_pos_x};
   assign body_fwd = {req_body_fwd_z, req_body_fwd_y, req_body_fwd_x};
   assign body_up  = {req_body_up_z, req_body_up_y, req_body_up_x};

   cco_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .body_pos    (body_pos),
      .body_fwd    (body_fwd),
      .body_up     (body_up),
      .camera_mode (mode_ff),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_entry     (q_wr_entry)
   );

   cco_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .wr_entry (q_wr_entry),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .rd_entry (q_rd_entry)
   );

   cco_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_entry   (q_rd_entry),
      .q_pop     (q_pop),
      .offsets   (off_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cam_pos   (cam_pos),
      .cam_fwd   (cam_fwd),
      .cam_up    (cam_up)
   );

   assign rsp_cam_pos_x = cam_pos[0];
   assign rsp_cam_pos_y = cam_pos[1];
   assign rsp_cam_pos_z = cam_pos[2];
   assign rsp_cam_fwd_x = cam_fwd[0];
   assign rsp_cam_fwd_y = cam_fwd[1];
   assign rsp_cam_fwd_z = cam_fwd[2];
   assign rsp_cam_up_x  = cam_up[0];
   assign rsp_cam_up_y  = cam_up[1];
   assign rsp_cam_up_z  = cam_up[2];

endmodule

// File: hw/rtl/cco_checker.sv
// Port-level checks for the chase camera core, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cco_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_cam_pos_x,
   input logic               csr_pready
);

   `CCO_CHECK_ALL(a_pready_high, csr_pready)
   `CCO_CHECK_ALL(a_reset_no_rsp, reset |=> !rsp_valid)
   `CCO_CHECK_ALL(a_reset_ready, reset |=> req_ready)
   `CCO_CHECK(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cam_pos_x))

endmodule

bind chase_camera_offset_transform_core cco_checker u_cco_checker (.*);

// File: tb/chase_camera_view_checker.sv
// Checker for the chase camera core: mirrors the registers, predicts each camera word, compares.
`timescale 1ns / 1ps
module chase_camera_view_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  cco_pkg::q16_type         req_body_pos_x,
   input  cco_pkg::q16_type         req_body_pos_y,
   input  cco_pkg::q16_type         req_body_pos_z,
   input  cco_pkg::q16_type         req_body_fwd_x,
   input  cco_pkg::q16_type         req_body_fwd_y,
   input  cco_pkg::q16_type         req_body_fwd_z,
   input  cco_pkg::q16_type         req_body_up_x,
   input  cco_pkg::q16_type         req_body_up_y,
   input  cco_pkg::q16_type         req_body_up_z,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  cco_pkg::q16_type         rsp_cam_pos_x,
   input  cco_pkg::q16_type         rsp_cam_pos_y,
   input  cco_pkg::q16_type         rsp_cam_pos_z,
   input  cco_pkg::q16_type         rsp_cam_fwd_x,
   input  cco_pkg::q16_type         rsp_cam_fwd_y,
   input  cco_pkg::q16_type         rsp_cam_fwd_z,
   input  cco_pkg::q16_type         rsp_cam_up_x,
   input  cco_pkg::q16_type         rsp_cam_up_y,
   input  cco_pkg::q16_type         rsp_cam_up_z,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic                     csr_pready,
   input  logic [cco_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output int                       pending_words,
   output int                       fail_count,
   output int                       words_checked,
   output int                       ring_pops
);
   import cco_pkg::*;

   localparam longint SAT_HI = 64'sd2147483647;
   localparam longint SAT_LO = -64'sd2147483648;

   // [0..2] position, [3..5] forward, [6..8] up
   typedef q16_type [8:0] cam_word_type;

   logic [1:0]   view_mode;
   q16_type      off_right;
   q16_type      off_up;
   q16_type      off_fwd;
   longint       held_fwd [3];
   longint       held_up [3];
   longint       ring_fwd [DELAY_DEPTH][3];
   longint       ring_up [DELAY_DEPTH][3];
   int           ring_head;
   int           ring_fill;
   cam_word_type expected_views [$];

   function automatic longint widen(input q16_type v);
      return longint'($signed(v));
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > SAT_HI)
         return SAT_HI;
      if (v < SAT_LO)
         return SAT_LO;
      return v;
   endfunction

   // exact product, then >> 16 rounding to nearest, ties toward +inf
   function automatic longint round_mul(input longint a, input longint b);
      longint p;
      p = a * b + 64'sd32768;
      return p >>> 16;
   endfunction

   function automatic string field_name(input int k);
      case (k)
         0: return "cam_pos_x";
         1: return "cam_pos_y";
         2: return "cam_pos_z";
         3: return "cam_fwd_x";
         4: return "cam_fwd_y";
         5: return "cam_fwd_z";
         6: return "cam_up_x";
         7: return "cam_up_y";
         default: return "cam_up_z";
      endcase
   endfunction

   function automatic cam_word_type advance_camera(input cam_word_type body);
      longint       p [3];
      longint       f [3];
      longint       u [3];
      longint       cr [3];
      longint       acc;
      int           slot;
      cam_word_type view;
      for (int k = 0; k < 3; k++) begin
         p[k] = widen(body[k]);
         f[k] = widen(body[3 + k]);
         u[k] = widen(body[6 + k]);
      end
      if (view_mode == MODE_GLUED) begin
         for (int k = 0; k < 3; k++) begin
            held_fwd[k] = f[k];
            held_up[k] = u[k];
         end
      end else if (view_mode == MODE_DELAYED) begin
         slot = (ring_head + ring_fill) % DELAY_DEPTH;
         for (int k = 0; k < 3; k++) begin
            ring_fwd[slot][k] = f[k];
            ring_up[slot][k] = u[k];
         end
         ring_fill++;
         if (ring_fill >= DELAY_DEPTH) begin
            for (int k = 0; k < 3; k++) begin
               held_fwd[k] = ring_fwd[ring_head][k];
               held_up[k] = ring_up[ring_head][k];
            end
            ring_head = (ring_head + 1) % DELAY_DEPTH;
            ring_fill--;
            ring_pops++;
         end
      end
      if (view_mode == MODE_GLUED || view_mode == MODE_DELAYED) begin
         cr[0] = clamp32(round_mul(held_up[1], held_fwd[2]) - round_mul(held_up[2], held_fwd[1]));
         cr[1] = clamp32(round_mul(held_up[2], held_fwd[0]) - round_mul(held_up[0], held_fwd[2]));
         cr[2] = clamp32(round_mul(held_up[0], held_fwd[1]) - round_mul(held_up[1], held_fwd[0]));
         for (int k = 0; k < 3; k++) begin
            acc = p[k];
            acc += clamp32(round_mul(held_fwd[k], widen(off_fwd)));
            acc += clamp32(round_mul(held_up[k], widen(off_up)));
            acc += clamp32(round_mul(cr[k], widen(off_right)));
            view[k] = q16_type'(clamp32(acc));
         end
      end else begin
         // fixed angles, and the unused mode code that behaves the same
         view[0] = q16_type'(clamp32(p[0] + widen(off_right)));
         view[1] = q16_type'(clamp32(p[1] + widen(off_up)));
         view[2] = q16_type'(clamp32(p[2] + widen(off_fwd)));
      end
      for (int k = 0; k < 3; k++) begin
         view[3 + k] = q16_type'(held_fwd[k]);
         view[6 + k] = q16_type'(held_up[k]);
      end
      return view;
   endfunction

   always @(posedge clock) begin
      cam_word_type body;
      cam_word_type got;
      cam_word_type want;
      if (reset) begin
         view_mode = MODE_FIXED;
         off_right = OFF_RIGHT_RESET;
         off_up = OFF_UP_RESET;
         off_fwd = OFF_FWD_RESET;
         for (int k = 0; k < 3; k++) begin
            held_fwd[k] = 0;
            held_up[k] = 0;
         end
         ring_head = 0;
         ring_fill = 0;
         expected_views.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[CSR_AW-1:2])
               REG_MODE:      view_mode = csr_pwdata[1:0];
               REG_OFF_RIGHT: off_right = csr_pwdata;
               REG_OFF_UP:    off_up = csr_pwdata;
               REG_OFF_FWD:   off_fwd = csr_pwdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            body = {req_body_up_z, req_body_up_y, req_body_up_x,
                    req_body_fwd_z, req_body_fwd_y, req_body_fwd_x,
                    req_body_pos_z, req_body_pos_y, req_body_pos_x};
            expected_views.push_back(advance_camera(body));
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_cam_up_z, rsp_cam_up_y, rsp_cam_up_x,
                   rsp_cam_fwd_z, rsp_cam_fwd_y, rsp_cam_fwd_x,
                   rsp_cam_pos_z, rsp_cam_pos_y, rsp_cam_pos_x};
            if (expected_views.size() == 0) begin
               $display("%0t: unexpected camera word, expected none, actual pos %h %h %h",
                        $time, got[0], got[1], got[2]);
               fail_count++;
            end else begin
               want = expected_views.pop_front();
               words_checked++;
               for (int k = 0; k < 9; k++) begin
                  if (got[k] !== want[k]) begin
                     $display("%0t: %s expected %h actual %h",
                              $time, field_name(k), want[k], got[k]);
                     fail_count++;
                  end
               end
            end
         end
      end
      pending_words <= expected_views.size();
   end

endmodule

// File: tb/chase_camera_offset_transform_core_tb.sv
// Testbench top for the chase camera core: reset, register setup, body updates and verdict.
`timescale 1ns / 1ps
module chase_camera_offset_transform_core_tb;
   import cco_pkg::*;

   localparam int         CYCLE_LIMIT   = 400000;
   localparam int         HOLD_CYCLES   = 64;
   localparam int         PHASE_WORDS   = 105;
   localparam int         PHASE_COUNT   = 9;
   localparam int         SETTLE_CYCLES = 12;
   localparam logic [1:0] MODE_FIXED_ALIAS = 2'd3;
   localparam q16_type    Q_ONE  = 32'h0001_0000;
   localparam q16_type    Q_HALF = 32'h0000_8000;
   localparam q16_type    Q_MAX  = 32'h7FFF_FFFF;
   localparam q16_type    Q_MIN  = 32'h8000_0000;
   localparam q16_type    Q_NEG1 = 32'hFFFF_FFFF;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   q16_type           req_body_pos_x = '0;
   q16_type           req_body_pos_y = '0;
   q16_type           req_body_pos_z = '0;
   q16_type           req_body_fwd_x = '0;
   q16_type           req_body_fwd_y = '0;
   q16_type           req_body_fwd_z = '0;
   q16_type           req_body_up_x = '0;
   q16_type           req_body_up_y = '0;
   q16_type           req_body_up_z = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   q16_type           rsp_cam_pos_x;
   q16_type           rsp_cam_pos_y;
   q16_type           rsp_cam_pos_z;
   q16_type           rsp_cam_fwd_x;
   q16_type           rsp_cam_fwd_y;
   q16_type           rsp_cam_fwd_z;
   q16_type           rsp_cam_up_x;
   q16_type           rsp_cam_up_y;
   q16_type           rsp_cam_up_z;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [CSR_AW-1:0] csr_paddr = '0;
   logic [31:0]       csr_pwdata = '0;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   int pending_words;
   int fail_count;
   int words_checked;
   int ring_pops;
   int words_sent = 0;
   int tx_idle_pct = 16;
   int rx_idle_pct = 62;
   int hold_requests = 0;
   int holds_done = 0;
   int cycle_count = 0;

   chase_camera_offset_transform_core u_dut (.*);

   chase_camera_view_checker u_checker (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still pending", cycle_count, pending_words);
         $display("** chase_camera_offset_transform_core: FAILED **");
         $finish;
      end
   end

   // output side: random stalls, plus a long hold whenever one is requested
   initial begin
      forever begin
         @(posedge clock);
         if (holds_done != hold_requests) begin
            holds_done = holds_done + 1;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   function automatic q16_type rand_q16();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 55)
         return q16_type'($urandom_range(0, 4 * Q_ONE)) - 2 * Q_ONE;
      else if (pick < 75)
         return q16_type'($urandom_range(0, 32'h01FF_FFFF)) - 32'h0100_0000;
      else if (pick < 90)
         return q16_type'($urandom);
      case ($urandom_range(4))
         0: return Q_MAX;
         1: return Q_MIN;
         2: return '0;
         3: return 32'd1;
         default: return Q_NEG1;
      endcase
   endfunction

   task automatic send_update(input q16_type px, py, pz, fx, fy, fz, ux, uy, uz);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_body_pos_x <= px;
      req_body_pos_y <= py;
      req_body_pos_z <= pz;
      req_body_fwd_x <= fx;
      req_body_fwd_y <= fy;
      req_body_fwd_z <= fz;
      req_body_up_x <= ux;
      req_body_up_y <= uy;
      req_body_up_z <= uz;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic send_random();
      send_update(rand_q16(), rand_q16(), rand_q16(), rand_q16(), rand_q16(),
                  rand_q16(), rand_q16(), rand_q16(), rand_q16());
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_words != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [1:0] index, input logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_camera(input logic [1:0] mode, input q16_type right, up, fwd);
      csr_write(REG_MODE, {30'd0, mode});
      csr_write(REG_OFF_RIGHT, right);
      csr_write(REG_OFF_UP, up);
      csr_write(REG_OFF_FWD, fwd);
   endtask

   initial begin
      logic [1:0] mode;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: fixed angles, offsets 0 / 2.0 / 15.0
      send_update(Q_MAX, Q_MAX, Q_MAX, rand_q16(), rand_q16(), rand_q16(),
                  rand_q16(), rand_q16(), rand_q16());
      send_update(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
      send_update('0, '0, '0, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
      wait_drained();
      set_camera(MODE_FIXED, Q_MIN, Q_MAX, Q_MIN);
      send_update(Q_MIN, Q_MAX, Q_MIN, '0, '0, '0, '0, '0, '0);
      send_update(Q_MAX, Q_MIN, Q_MAX, '0, '0, '0, '0, '0, '0);
      wait_drained();
      set_camera(MODE_FIXED_ALIAS, 32'h0001_8000, Q_NEG1, 32'h7FFF_0000);
      send_random();
      send_update(32'h0001_0000, Q_MIN, 32'h0000_FFFF, Q_ONE, '0, '0, '0, Q_ONE, '0);
      wait_drained();
      set_camera(MODE_GLUED, Q_MAX, Q_MIN, Q_MAX);
      send_update('0, '0, '0, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
      send_update(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);
      send_update(Q_ONE, 2 * Q_ONE, 3 * Q_ONE, '0, '0, Q_ONE, '0, Q_ONE, '0);
      send_update(Q_MIN, Q_MAX, '0, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
      wait_drained();
      // half-unit offsets put rounding ties on the products
      set_camera(MODE_GLUED, Q_HALF, Q_HALF, Q_HALF);
      send_update('0, '0, '0, 32'd1, Q_NEG1, 32'd3, Q_NEG1, 32'd1, 32'hFFFF_FFFD);
      send_update(32'd7, Q_NEG1, '0, 32'hFFFF_FFFD, 32'd3, 32'd5, 32'd1, 32'd1, Q_NEG1);
      wait_drained();
      // delayed mode starts from the orientation held by glued mode
      set_camera(MODE_DELAYED, OFF_RIGHT_RESET, OFF_UP_RESET, OFF_FWD_RESET);
      repeat (4) send_random();

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         wait_drained();
         tx_idle_pct = (phase < 3) ? 16 : (phase < 6) ? 62 : 0;
         rx_idle_pct = (phase < 3) ? 62 : (phase < 6) ? 16 : 0;
         case (phase % 5)
            0, 3: mode = MODE_DELAYED;
            1, 4: mode = MODE_GLUED;
            default: mode = (phase == 7) ? MODE_FIXED_ALIAS : MODE_FIXED;
         endcase
         if (phase == 6)
            set_camera(MODE_DELAYED, Q_MAX, Q_MIN, Q_MAX);
         else if (phase == 8)
            set_camera(MODE_DELAYED, '0, '0, '0);
         else
            set_camera(mode, rand_q16(), rand_q16(), rand_q16());
         if (phase >= 6)
            hold_requests = hold_requests + 1;
         repeat (PHASE_WORDS) send_random();
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Covered %0d body updates across fixed, aliased, glued and delayed modes,",
               words_sent);
      $display("%0d camera words compared, %0d ring pops, %0d long output holds.",
               words_checked, ring_pops, holds_done);
      if (fail_count == 0 && pending_words == 0)
         $display("** chase_camera_offset_transform_core: PASSED **");
      else
         $display("** chase_camera_offset_transform_core: FAILED **");
      $finish;
   end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/cco_pkg.sv
hw/rtl/cco_front.sv
hw/rtl/cco_fifo.sv
hw/rtl/cco_back.sv
hw/rtl/chase_camera_offset_transform_core.sv
hw/rtl/cco_checker.sv
tb/chase_camera_view_checker.sv
tb/chase_camera_offset_transform_core_tb.sv
